// File: hw/rtl/fud_pkg.sv
// ----------------------------------------------------------------------------
// fud_pkg
// Shared types and character constants for the form-urlencoded decoder.
// ----------------------------------------------------------------------------
package fud_pkg;

  localparam logic [7:0] CHAR_PLUS    = 8'h2B;  // '+'
  localparam logic [7:0] CHAR_PERCENT = 8'h25;  // '%'
  localparam logic [7:0] CHAR_EQUALS  = 8'h3D;  // '='
  localparam logic [7:0] CHAR_AMP     = 8'h26;  // '&'
  localparam logic [7:0] CHAR_SPACE   = 8'h20;  // ' '

  typedef enum logic [1:0] {
    ESC_NONE = 2'd0,
    ESC_PCT  = 2'd1,
    ESC_HI   = 2'd2
  } esc_phase_t;

  typedef struct packed {
    logic       value_mode;
    esc_phase_t escape_phase;
    logic [3:0] high_nibble;
    logic       dropping;
  } parse_state_t;

  localparam parse_state_t STATE_RESET = '{
    value_mode:   1'b0,
    escape_phase: ESC_NONE,
    high_nibble:  4'd0,
    dropping:     1'b0
  };

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       in_value;
    logic       key_done;
    logic       pair_done;
    logic       error;
  } result_t;

endpackage

// File: hw/rtl/fud_step.sv
// ----------------------------------------------------------------------------
// fud_step
// One decode step: current parse state and one byte in, next state and an
// optional result out. Purely combinational.
// ----------------------------------------------------------------------------
module fud_step (
  input  fud_pkg::parse_state_t state,
  input  logic [7:0]            in_byte,
  input  logic                  in_last,
  output fud_pkg::parse_state_t state_next,
  output logic                  emit,
  output fud_pkg::result_t      result
);
  import fud_pkg::*;

  logic       hex_ok;
  logic [3:0] hex_val;
  logic       raise_err;
  logic       normal;

  // hex digit decode, either case
  always_comb begin
    hex_ok  = 1'b1;
    hex_val = 4'd0;
    if (in_byte >= 8'h30 && in_byte <= 8'h39) begin
      hex_val = 4'(in_byte - 8'h30);
    end else if (in_byte >= 8'h61 && in_byte <= 8'h66) begin
      hex_val = 4'(in_byte - 8'h57);
    end else if (in_byte >= 8'h41 && in_byte <= 8'h46) begin
      hex_val = 4'(in_byte - 8'h37);
    end else begin
      hex_ok = 1'b0;
    end
  end

  always_comb begin
    state_next        = state;
    emit              = 1'b0;
    raise_err         = 1'b0;
    normal            = 1'b0;
    result            = '0;
    result.in_value   = state.value_mode;

    if (state.dropping) begin
      if (in_last) begin
        state_next = STATE_RESET;
      end
    end else begin
      case (state.escape_phase)
        ESC_PCT: begin
          if (!hex_ok || in_last) begin
            raise_err = 1'b1;
          end else begin
            state_next.high_nibble  = hex_val;
            state_next.escape_phase = ESC_HI;
          end
        end
        ESC_HI: begin
          if (!hex_ok) begin
            raise_err = 1'b1;
          end else begin
            normal                  = 1'b1;
            result.out_byte         = {state.high_nibble, hex_val};
            result.byte_valid       = 1'b1;
            state_next.escape_phase = ESC_NONE;
            state_next.high_nibble  = 4'd0;
          end
        end
        ESC_NONE: begin
          if (in_byte == CHAR_PLUS) begin
            normal            = 1'b1;
            result.out_byte   = CHAR_SPACE;
            result.byte_valid = 1'b1;
          end else if (in_byte == CHAR_PERCENT) begin
            if (in_last) begin
              raise_err = 1'b1;
            end else begin
              state_next.escape_phase = ESC_PCT;
            end
          end else if (!state.value_mode && in_byte == CHAR_EQUALS) begin
            normal                = 1'b1;
            result.key_done       = 1'b1;
            state_next.value_mode = 1'b1;
          end else if (state.value_mode && in_byte == CHAR_AMP) begin
            normal                = 1'b1;
            result.pair_done      = 1'b1;
            state_next.value_mode = 1'b0;
          end else begin
            normal            = 1'b1;
            result.out_byte   = in_byte;
            result.byte_valid = 1'b1;
          end
        end
        default: begin
          raise_err = 1'b1;
        end
      endcase

      if (raise_err) begin
        emit              = 1'b1;
        result            = '0;
        result.in_value   = state.value_mode;
        result.error      = 1'b1;
        if (in_last) begin
          state_next = STATE_RESET;
        end else begin
          state_next.escape_phase = ESC_NONE;
          state_next.high_nibble  = 4'd0;
          state_next.dropping     = 1'b1;
        end
      end else if (normal) begin
        emit = 1'b1;
        if (in_last) begin
          // end of body closes the key (if open) and the pair
          if (!state.value_mode) begin
            result.key_done = 1'b1;
          end
          result.pair_done = 1'b1;
          state_next       = STATE_RESET;
        end
      end
    end
  end

endmodule

// File: hw/rtl/form_urlencoded_decoder_unit.sv
// ----------------------------------------------------------------------------
// form_urlencoded_decoder_unit
// Streaming decoder for an application/x-www-form-urlencoded body.
// ----------------------------------------------------------------------------
// Usage:
//  - Input channel (in_valid/in_ready, in_byte, in_last) takes one raw byte
//    per transfer; in_last marks the final byte of a body.
//  - Output channel (out_valid/out_ready) carries at most one result per
//    input byte: a decoded byte, a key/pair terminator, or an error flag.
//    Escape bytes ('%' and the first hex digit) and bytes dropped after an
//    error give no result.
//  - Path: a byte taken on the input channel sits in the input register, is
//    decoded there and lands in the result register, which drives the
//    output channel.
//  - Throughput: one byte per cycle while no result is stalled, set by the
//    single decode step between input register and result register; the
//    parse state updates as each byte leaves the input register.
//  - Stall: when the receiver holds out_ready low the result register holds,
//    the input register holds its byte, and in_ready drops. A byte that
//    yields no result still moves on, so stalls only bite on results.
//  - Reset (rst, synchronous): both registers empty, parse state back to
//    key mode with no escape pending and no error.
// ----------------------------------------------------------------------------
module form_urlencoded_decoder_unit (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       byte_valid,
  output logic       in_value,
  output logic       key_done,
  output logic       pair_done,
  output logic       error
);
  import fud_pkg::*;

  // input register
  logic         s1_valid;
  logic [7:0]   s1_byte;
  logic         s1_last;

  // parse state
  parse_state_t state;
  parse_state_t state_next;

  // decode step outputs
  logic         step_emit;
  result_t      step_result;

  // result register
  result_t      res;

  logic         out_free;
  logic         s1_advance;

  fud_step u_step (
    .state      (state),
    .in_byte    (s1_byte),
    .in_last    (s1_last),
    .state_next (state_next),
    .emit       (step_emit),
    .result     (step_result)
  );

  // result slot can take a new result this cycle
  assign out_free   = !out_valid || out_ready;
  // byte in the input register retires if it needs no slot or one is free
  assign s1_advance = s1_valid && (!step_emit || out_free);
  assign in_ready   = !s1_valid || s1_advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_byte <= in_byte;
      s1_last <= in_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= STATE_RESET;
    end else if (s1_advance) begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= s1_advance && step_emit;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance && step_emit) begin
      res <= step_result;
    end
  end

  assign out_byte   = res.out_byte;
  assign byte_valid = res.byte_valid;
  assign in_value   = res.in_value;
  assign key_done   = res.key_done;
  assign pair_done  = res.pair_done;
  assign error      = res.error;

endmodule

// File: hw/rtl/fud_checker.sv
// ----------------------------------------------------------------------------
// fud_checker
// Port-level checks for the form-urlencoded decoder, bound to the top level.
// ----------------------------------------------------------------------------
module fud_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte,
  input logic       byte_valid,
  input logic       in_value,
  input logic       key_done,
  input logic       pair_done,
  input logic       error
);

  // stalled result stays valid and holds out_byte, byte_valid, error and pair_done
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) &&
      $stable(byte_valid) && $stable(error) && $stable(pair_done))
    else $error("result changed while stalled");

  // error result carries no byte and no terminator
  a_err_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && error |-> !byte_valid && !key_done && !pair_done &&
      out_byte == 8'd0)
    else $error("error result carries data");

  // a result without a byte must be a terminator or an error
  a_no_empty: assert property (@(posedge clk) disable iff (rst)
    out_valid && !byte_valid |-> error || key_done || pair_done)
    else $error("empty result");

  // a key can only end while parsing the key
  a_key_mode: assert property (@(posedge clk) disable iff (rst)
    out_valid && key_done |-> !in_value)
    else $error("key_done in value mode");

  // no result straight after reset
  a_reset: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind form_urlencoded_decoder_unit fud_checker u_fud_checker (.*);

// File: tb/form_urlencoded_decoder_unit_test.sv
// ----------------------------------------------------------------------------
// form_urlencoded_decoder_unit_test
// Self-checking bench for the form-urlencoded decoder. Form bodies are queued
// by a stimulus process and fed byte by byte through the input channel. Each
// accepted byte is run through a local decoder model, and every result
// transfer is checked field by field against the oldest predicted result.
// ----------------------------------------------------------------------------
module form_urlencoded_decoder_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import fud_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_LIMIT = 5000;
  localparam int TAIL_CYCLES = 16;

  typedef struct {
    logic [7:0] b;
    logic       last;
  } form_byte_t;

  typedef enum int {
    BODY_CLEAN,
    BODY_BROKEN,
    BODY_NOISE
  } body_kind_t;

  // DUT ports; the inputs are known from time zero
  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] in_byte = 8'h00;
  logic       in_last = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] out_byte;
  logic       byte_valid;
  logic       in_value;
  logic       key_done;
  logic       pair_done;
  logic       error;

  // Stimulus and scoreboard
  form_byte_t   form_bytes[$];      // bytes waiting for the driver
  result_t      pending_results[$]; // predicted results not yet seen
  logic [7:0]   body_q[$];          // body under construction
  parse_state_t parse_st;           // model copy of the parse state
  form_byte_t   next_byte;
  logic         in_took = 1'b0;     // input transfer at the last rising edge
  logic         idle_on = 1'b1;     // random gaps and stalls allowed
  int           gap_left = 0;
  int           stall_left = 0;
  int           items_queued = 0;
  int           mismatch_count = 0;
  int           cycle_count = 0;
  int           drain_cycles;

  form_urlencoded_decoder_unit uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_byte   (in_byte),
    .in_last   (in_last),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_byte  (out_byte),
    .byte_valid(byte_valid),
    .in_value  (in_value),
    .key_done  (key_done),
    .pair_done (pair_done),
    .error     (error)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Local decoder model
  // --------------------------------------------------------------------------

  // bit 4 flags a legal hex digit, bits 3:0 hold its value
  function automatic logic [4:0] hex_nibble(input logic [7:0] c);
    logic [7:0] d;
    d = 8'h00;
    if (c >= "0" && c <= "9") begin
      d = c - "0";
      return {1'b1, d[3:0]};
    end
    if (c >= "a" && c <= "f") begin
      d = c - "a" + 8'd10;
      return {1'b1, d[3:0]};
    end
    if (c >= "A" && c <= "F") begin
      d = c - "A" + 8'd10;
      return {1'b1, d[3:0]};
    end
    return 5'b0_0000;
  endfunction

  // Advance the model by one accepted byte; queue the result it gives, if any
  task automatic decode_form_byte(input logic [7:0] c, input logic last);
    result_t    r;
    logic [4:0] h;
    logic       mode;
    logic       emit;
    logic       bad;
    r    = '0;
    mode = parse_st.value_mode;
    h    = hex_nibble(c);
    emit = 1'b0;
    bad  = 1'b0;
    if (parse_st.dropping) begin
      // after an error everything up to last is swallowed
      if (last) parse_st = STATE_RESET;
    end else if (parse_st.escape_phase == ESC_PCT) begin
      // first digit: a bad digit, or the body ending here, is an error
      if (!h[4] || last) begin
        bad = 1'b1;
      end else begin
        parse_st.high_nibble  = h[3:0];
        parse_st.escape_phase = ESC_HI;
      end
    end else begin
      emit = 1'b1;
      if (parse_st.escape_phase == ESC_HI) begin
        if (!h[4]) begin
          bad  = 1'b1;
          emit = 1'b0;
        end else begin
          r.out_byte            = {parse_st.high_nibble, h[3:0]};
          r.byte_valid          = 1'b1;
          parse_st.escape_phase = ESC_NONE;
          parse_st.high_nibble  = 4'd0;
        end
      end else if (c == CHAR_PLUS) begin
        r.out_byte   = CHAR_SPACE;
        r.byte_valid = 1'b1;
      end else if (c == CHAR_PERCENT) begin
        emit = 1'b0;
        if (last) bad = 1'b1;
        else parse_st.escape_phase = ESC_PCT;
      end else if (!mode && c == CHAR_EQUALS) begin
        r.key_done          = 1'b1;
        parse_st.value_mode = 1'b1;
      end else if (mode && c == CHAR_AMP) begin
        r.pair_done         = 1'b1;
        parse_st.value_mode = 1'b0;
      end else begin
        r.out_byte   = c;
        r.byte_valid = 1'b1;
      end
      // last byte closes the key if still open, and always the pair
      if (emit && last) begin
        if (!mode) r.key_done = 1'b1;
        r.pair_done = 1'b1;
        parse_st    = STATE_RESET;
      end
    end
    if (bad) begin
      r       = '0;
      r.error = 1'b1;
      emit    = 1'b1;
      if (last) begin
        parse_st = STATE_RESET;
      end else begin
        parse_st.escape_phase = ESC_NONE;
        parse_st.high_nibble  = 4'd0;
        parse_st.dropping     = 1'b1;
      end
    end
    r.in_value = mode;
    if (emit) pending_results.push_back(r);
  endtask

  // --------------------------------------------------------------------------
  // Checking
  // --------------------------------------------------------------------------

  task automatic flag_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $time, msg);
    mismatch_count++;
  endtask

  task automatic check_field(input string name, input logic [7:0] got,
                             input logic [7:0] want);
    if (got !== want)
      flag_mismatch($sformatf("%s got %0h, expected %0h", name, got, want));
  endtask

  // Monitor: result transfer is checked before the input transfer of the
  // same edge is modelled, so the queue front is always the older item.
  always @(posedge clk) begin
    if (rst) begin
      in_took = 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          flag_mismatch("result transfer with nothing predicted");
        end else begin
          check_field("out_byte", out_byte, pending_results[0].out_byte);
          check_field("byte_valid", {7'd0, byte_valid},
                      {7'd0, pending_results[0].byte_valid});
          check_field("in_value", {7'd0, in_value},
                      {7'd0, pending_results[0].in_value});
          check_field("key_done", {7'd0, key_done},
                      {7'd0, pending_results[0].key_done});
          check_field("pair_done", {7'd0, pair_done},
                      {7'd0, pending_results[0].pair_done});
          check_field("error", {7'd0, error}, {7'd0, pending_results[0].error});
          void'(pending_results.pop_front());
        end
      end
      in_took = in_valid && in_ready;
      if (in_took) decode_form_byte(in_byte, in_last);
    end
  end

  // --------------------------------------------------------------------------
  // Driver and sink
  // --------------------------------------------------------------------------

  // Sender: holds a byte until its transfer, then either idles a burst or
  // presents the next queued byte.
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_took) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (idle_on && form_bytes.size() > 0 && $urandom_range(0, 7) == 0) begin
        gap_left = $urandom_range(0, 13);
        in_valid <= 1'b0;
      end else if (form_bytes.size() > 0) begin
        next_byte = form_bytes.pop_front();
        in_byte  <= next_byte.b;
        in_last  <= next_byte.last;
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: drops out_ready in random stall bursts
  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 6) == 0) begin
      stall_left = $urandom_range(0, 13);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  task automatic add_item(input logic [7:0] b, input logic last);
    form_byte_t fb;
    fb.b    = b;
    fb.last = last;
    form_bytes.push_back(fb);
    items_queued++;
  endtask

  function automatic logic [7:0] hex_char(input logic [3:0] n);
    if (n < 4'd10) return "0" + n;
    return ($urandom_range(0, 1) ? "A" : "a") + n - 8'd10;
  endfunction

  function automatic logic [7:0] non_hex_byte();
    logic [7:0] c;
    c = 8'($urandom_range(0, 255));
    while (hex_nibble(c) != 5'b0_0000) c = 8'($urandom_range(0, 255));
    return c;
  endfunction

  // One key or value token: plain byte, '+' or a well-formed escape
  task automatic add_token();
    int         kind;
    logic [7:0] c;
    kind = $urandom_range(0, 9);
    c    = 8'($urandom_range(0, 255));
    if (kind <= 3) begin
      while (c == CHAR_PERCENT || c == CHAR_EQUALS || c == CHAR_AMP)
        c = 8'($urandom_range(0, 255));
      body_q.push_back(c);
    end else if (kind <= 5) begin
      body_q.push_back(8'("a" + $urandom_range(0, 25)));
    end else if (kind == 6) begin
      body_q.push_back(CHAR_PLUS);
    end else begin
      body_q.push_back(CHAR_PERCENT);
      body_q.push_back(hex_char(c[7:4]));
      body_q.push_back(hex_char(c[3:0]));
    end
  endtask

  // Build one body and queue it, last flag on its final byte
  task automatic queue_form_body(input body_kind_t kind);
    int npairs;
    int cut;
    int variant;
    body_q.delete();
    if (kind == BODY_NOISE) begin
      repeat ($urandom_range(1, 12)) body_q.push_back(8'($urandom_range(0, 255)));
    end else begin
      npairs = $urandom_range(1, 4);
      for (int p = 0; p < npairs; p++) begin
        if (p > 0) body_q.push_back(CHAR_AMP);
        repeat ($urandom_range(0, 4)) add_token();
        if ($urandom_range(0, 9) != 0) begin
          body_q.push_back(CHAR_EQUALS);
          repeat ($urandom_range(0, 4)) add_token();
        end
      end
      if (kind == BODY_BROKEN) begin
        // cut the body somewhere and splice in a malformed escape
        cut = $urandom_range(0, body_q.size());
        while (body_q.size() > cut) void'(body_q.pop_back());
        variant = $urandom_range(0, 3);
        body_q.push_back(CHAR_PERCENT);
        if (variant == 1 || variant == 3) body_q.push_back(hex_char(4'($urandom_range(0, 15))));
        if (variant <= 1) begin
          body_q.push_back(non_hex_byte());
          repeat ($urandom_range(0, 3)) add_token();
        end
      end
    end
    if (body_q.size() == 0) body_q.push_back("x");
    foreach (body_q[i]) add_item(body_q[i], i == body_q.size() - 1);
  endtask

  task automatic queue_random_until(input int target);
    int pick;
    while (items_queued < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 75) queue_form_body(BODY_CLEAN);
      else if (pick < 87) queue_form_body(BODY_BROKEN);
      else queue_form_body(BODY_NOISE);
    end
  endtask

  // Wait for the queue to empty and the sender to go idle, then for every predicted result
  task automatic wait_drained();
    while (form_bytes.size() > 0 || in_valid) @(posedge clk);
    drain_cycles = 0;
    while (pending_results.size() > 0 && drain_cycles < DRAIN_LIMIT) begin
      @(posedge clk);
      drain_cycles++;
    end
  endtask

  // --------------------------------------------------------------------------
  // Run control
  // --------------------------------------------------------------------------

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("** form_urlencoded_decoder_unit: FAILED **");
    $finish;
  end

  initial begin
    parse_st = STATE_RESET;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Literal '&' in key, '=' ends key, lower-case escape, literal '=' in
    // value, '&' ends pair, empty key and empty value, extreme bytes, '+',
    // mixed-case escape whose second digit is the last byte.
    add_item(CHAR_AMP, 1'b0);
    add_item(CHAR_EQUALS, 1'b0);
    add_item(CHAR_PERCENT, 1'b0);
    add_item("4", 1'b0);
    add_item("a", 1'b0);
    add_item(CHAR_EQUALS, 1'b0);
    add_item(CHAR_AMP, 1'b0);
    add_item(CHAR_EQUALS, 1'b0);
    add_item(CHAR_AMP, 1'b0);
    add_item(8'h00, 1'b0);
    add_item(8'hFF, 1'b0);
    add_item(CHAR_PLUS, 1'b0);
    add_item(CHAR_PERCENT, 1'b0);
    add_item("F", 1'b0);
    add_item("f", 1'b1);
    // bad first digit, then bytes dropped up to and including last
    add_item(CHAR_PERCENT, 1'b0);
    add_item("g", 1'b0);
    add_item("x", 1'b0);
    add_item("y", 1'b1);
    // bad second digit on the last byte
    add_item(CHAR_PERCENT, 1'b0);
    add_item("1", 1'b0);
    add_item("z", 1'b1);
    // escape cut short by last, after '%' and after the first digit
    add_item(CHAR_PERCENT, 1'b1);
    add_item(CHAR_PERCENT, 1'b0);
    add_item("7", 1'b1);
    // trailing '=' as last: key and pair end together
    add_item(CHAR_EQUALS, 1'b1);

    // sender holds off until the directed part has fully drained
    wait_drained();
    queue_random_until(items_queued + 620);
    wait_drained();
    queue_random_until(items_queued + 530);

    // closing stretch without gaps or stalls, once any burst has run out
    while (form_bytes.size() > 0 || gap_left > 0 || stall_left > 0) @(posedge clk);
    idle_on = 1'b0;
    queue_random_until(items_queued + 150);
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);

    if (pending_results.size() != 0)
      flag_mismatch($sformatf("%0d predicted results never arrived",
                              pending_results.size()));
    if (mismatch_count == 0) begin
      $display("** form_urlencoded_decoder_unit: PASSED **");
    end else begin
      $display("** form_urlencoded_decoder_unit: FAILED **");
    end
    $finish;
  end

endmodule
